// ===== rtl/pst_pkg.sv =====
`timescale 1ns / 1ps

package pst_pkg;

	localparam int DEPTH_DEFAULT = 1024;

	localparam int SIZE_W = 11;
	localparam int POS_W  = 11;
	localparam int AMT_W  = 32;
	localparam int SUM_W  = 64;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// register index taken from paddr above the byte offset
	localparam logic [PADDR_W-3:0] REG_SIZE_IN_USE = 1'b0;

	localparam logic KIND_ADD   = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

endpackage

// ===== rtl/pst_ram.sv =====
`timescale 1ns / 1ps

module pst_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/pst_cfg.sv =====
`timescale 1ns / 1ps

module pst_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pst_pkg::PADDR_W-1:0]  paddr,
	input  logic [pst_pkg::PDATA_W-1:0]  pwdata,
	output logic [pst_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output logic [pst_pkg::SIZE_W-1:0]   size_in_use
);

	import pst_pkg::*;

	logic [PADDR_W-3:0] reg_idx;
	logic [SIZE_W-1:0]  size_q;
	logic               wr_hit;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_hit  = psel && penable && pwrite && (reg_idx == REG_SIZE_IN_USE);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (wr_hit) begin
			size_q <= pwdata[SIZE_W-1:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SIZE_IN_USE: prdata = PDATA_W'(size_q);
			default:         prdata = '0;
		endcase
	end

	assign size_in_use = size_q;

endmodule

// ===== rtl/pst_walk.sv =====
`timescale 1ns / 1ps

module pst_walk #(
	parameter int DEPTH = pst_pkg::DEPTH_DEFAULT,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [pst_pkg::SIZE_W-1:0]  size_in_use,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        kind,
	input  logic signed [pst_pkg::POS_W-1:0] position,
	input  logic signed [pst_pkg::AMT_W-1:0] amount,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [pst_pkg::SUM_W-1:0] prefix_sum,
	output logic                        wr_en,
	output logic [AW-1:0]               wr_addr,
	output logic [pst_pkg::SUM_W-1:0]   wr_data,
	output logic                        rd_en,
	output logic [AW-1:0]               rd_addr,
	input  logic [pst_pkg::SUM_W-1:0]   rd_data
);

	import pst_pkg::*;

	localparam int NB = ($clog2(DEPTH + 1) > SIZE_W) ? $clog2(DEPTH + 1) : SIZE_W;
	localparam int IW = NB + 1;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_WALK  = 3'b100
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     clr_q;
	logic              pend_q;
	logic              out_valid_q;
	logic [IW-1:0]     idx_q;
	logic [IW-1:0]     n_q;
	logic              kind_q;
	logic [AMT_W-1:0]  amt_q;
	logic [SUM_W-1:0]  acc_q;
	logic [AW-1:0]     pend_addr_q;
	logic [SUM_W-1:0]  out_sum_q;

	logic [IW-1:0]     size_ext;
	logic [IW-1:0]     n_c;
	logic [IW-1:0]     pos1;
	logic              accept;
	logic              add_skip;
	logic [IW-1:0]     low_bit;
	logic [IW-1:0]     idx_next;
	logic [IW-1:0]     idx_m1;
	logic              more;
	logic              finish;
	logic              can_out;
	logic              out_load;
	logic [SUM_W-1:0]  add_b;
	logic [SUM_W-1:0]  sum;

	// clamp of the configured size and the tree index of the item
	assign size_ext = IW'(size_in_use);
	assign n_c      = (size_ext == '0) ? IW'(1) :
	                  (size_ext > IW'(DEPTH)) ? IW'(DEPTH) : size_ext;
	assign pos1     = IW'(position[POS_W-2:0]) + IW'(1);
	assign add_skip = position[POS_W-1] || (pos1 > n_c);

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// tree step: up for add, down for query
	assign low_bit  = idx_q & (~idx_q + IW'(1));
	assign idx_next = (kind_q == KIND_QUERY) ? (idx_q - low_bit) : (idx_q + low_bit);
	assign idx_m1   = idx_q - IW'(1);
	assign more     = (kind_q == KIND_QUERY) ? (idx_q != '0) : (idx_q <= n_q);
	assign finish   = (state_q == ST_WALK) && !more && !pend_q;
	assign can_out  = !out_valid_q || out_ready;
	assign out_load = finish && (kind_q == KIND_QUERY) && can_out;

	// shared adder
	assign add_b = (kind_q == KIND_QUERY) ? acc_q : {{(SUM_W - AMT_W){amt_q[AMT_W-1]}}, amt_q};
	assign sum   = rd_data + add_b;

	assign rd_en   = (state_q == ST_WALK) && more;
	assign rd_addr = idx_m1[AW-1:0];
	assign wr_en   = (state_q == ST_CLEAR) ||
	                 ((state_q == ST_WALK) && pend_q && (kind_q == KIND_ADD));
	assign wr_addr = (state_q == ST_CLEAR) ? clr_q : pend_addr_q;
	assign wr_data = (state_q == ST_CLEAR) ? '0 : sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && !((kind == KIND_ADD) && add_skip)) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					pend_q <= more;
					if (finish) begin
						if (kind_q == KIND_ADD) begin
							state_q <= ST_IDLE;
						end else if (can_out) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			amt_q  <= amount;
			n_q    <= n_c;
			acc_q  <= '0;
			if (kind == KIND_QUERY) begin
				idx_q <= position[POS_W-1] ? '0 : ((pos1 > n_c) ? n_c : pos1);
			end else begin
				idx_q <= pos1;
			end
		end else if (state_q == ST_WALK) begin
			if (more) begin
				idx_q       <= idx_next;
				pend_addr_q <= idx_m1[AW-1:0];
			end
			if (pend_q && (kind_q == KIND_QUERY)) begin
				acc_q <= sum;
			end
			if (out_load) begin
				out_sum_q <= acc_q;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign prefix_sum = out_sum_q;

	a_pend_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (state_q == ST_WALK))
		else $error("read in flight outside walk");

	a_wr_source: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_CLEAR) || (kind_q == KIND_ADD))
		else $error("tree written during a query");

	a_query_idx: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_WALK) && (kind_q == KIND_QUERY)) |-> (idx_q <= n_q))
		else $error("query index beyond size");

	a_out_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past((state_q == ST_WALK) && (kind_q == KIND_QUERY)))
		else $error("result without a query");

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |=> !$past(accept))
		else $error("transaction accepted while clearing");

endmodule

// ===== rtl/prefix_sum_tree_update_query.sv =====
`timescale 1ns / 1ps

// Binary indexed tree of 64-bit partial sums kept in one RAM of DEPTH entries. kind 0 adds the
// sign-extended amount at position (ignored when position is negative or not below the size in
// use); kind 1 returns the wrapped sum of positions 0..position, 0 for a negative position and
// clamped to the last position when past the end. After reset the RAM is cleared while in_ready
// stays low; configuration writes are taken meanwhile. A transaction then walks the tree nodes
// on its path, at most log2(DEPTH)+1 of them: the walk does one RAM read per cycle, folds each
// word in the next cycle through a single shared 64-bit adder and then closes. A negative query
// still enters the walk with nothing to read, and an add outside the size in use ends at its
// accept. A result waits in an output register; a query that ends while the previous result
// is still not taken holds there until it is.
module prefix_sum_tree_update_query #(
	parameter int DEPTH = pst_pkg::DEPTH_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pst_pkg::PADDR_W-1:0]        paddr,
	input  logic [pst_pkg::PDATA_W-1:0]        pwdata,
	output logic [pst_pkg::PDATA_W-1:0]        prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               kind,
	input  logic signed [pst_pkg::POS_W-1:0]   position,
	input  logic signed [pst_pkg::AMT_W-1:0]   amount,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [pst_pkg::SUM_W-1:0]   prefix_sum
);

	import pst_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [SIZE_W-1:0] size_in_use;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [SUM_W-1:0]  wr_data;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [SUM_W-1:0]  rd_data;

	pst_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.size_in_use (size_in_use)
	);

	pst_walk #(
		.DEPTH (DEPTH)
	) u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.size_in_use (size_in_use),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.position    (position),
		.amount      (amount),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.prefix_sum  (prefix_sum),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data)
	);

	pst_ram #(
		.WIDTH (SUM_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule
